// ===== design/qlu_pkg.sv =====
// ----------------------------------------------------------------------------
// qlu_pkg: shared types and constants of the quoted literal unescaper
// Result kinds, decoder modes, character codes and the result word layout.
// ----------------------------------------------------------------------------
package qlu_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CODE_BS     = 8'd8;
  localparam logic [7:0] CODE_FF     = 8'd12;
  localparam logic [7:0] CODE_LF     = 8'd10;
  localparam logic [7:0] CODE_CR     = 8'd13;
  localparam logic [7:0] CODE_TAB    = 8'd9;

  localparam logic [7:0] OPEN_RESET  = 8'd34;
  localparam logic [7:0] CLOSE_RESET = 8'd34;

  typedef enum logic {
    CFG_OPEN  = 1'b0,
    CFG_CLOSE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_OCTAL  = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] count;
    logic        last;
  } res_t;

  // Zero, one or two result words produced by one accepted byte.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t make_res(kind_t kind, logic [7:0] value, logic [15:0] count);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.count = count;
    r.last  = 1'b0;
    return r;
  endfunction

  // Shown count saturates at 16 bits whatever the counter width.
  function automatic logic [15:0] count_out(logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

  function automatic logic [7:0] escape_map(logic [7:0] c);
    logic [7:0] v;
    case (c)
      CHAR_B:  v = CODE_BS;
      CHAR_F:  v = CODE_FF;
      CHAR_N:  v = CODE_LF;
      CHAR_R:  v = CODE_CR;
      CHAR_T:  v = CODE_TAB;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

// ===== design/qlu_if.sv =====
// ----------------------------------------------------------------------------
// qlu_if: stream channels of the quoted literal unescaper
// Input byte channel and result channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface qlu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_req;

  modport source (output valid, output in_byte, output start_req, input ready);
  modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface qlu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  char_value;
  logic [15:0] char_count;
  logic        last;

  modport source (output valid, output result_kind, output char_value,
                  output char_count, output last, input ready);
  modport sink   (input valid, input result_kind, input char_value,
                  input char_count, input last, output ready);
endinterface

// ===== design/qlu_dec.sv =====
// ----------------------------------------------------------------------------
// qlu_dec: escape decoder state and per-byte result logic
// Holds the configuration and decoder state; turns one byte into up to two words.
// ----------------------------------------------------------------------------
module qlu_dec (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  qlu_in_if.sink              in_chan,
  input  logic                room,
  output qlu_pkg::push_t      push
);

  typedef struct packed {
    logic                          emit;
    qlu_pkg::res_t                 r;
    qlu_pkg::mode_t                mode;
    logic [qlu_pkg::COUNT_BITS-1:0] cnt;
  } body_t;

  logic [7:0]                     open_char;
  logic [7:0]                     close_char;
  qlu_pkg::mode_t                 mode;
  qlu_pkg::mode_t                 mode_next;
  logic [7:0]                     octal_value;
  logic [7:0]                     octal_value_next;
  logic [1:0]                     octal_digits;
  logic [1:0]                     octal_digits_next;
  logic [qlu_pkg::COUNT_BITS-1:0] emitted_count;
  logic [qlu_pkg::COUNT_BITS-1:0] emitted_count_next;
  logic                           accept;

  function automatic body_t body_byte(logic [7:0] c, logic [7:0] close_c,
                                      logic [qlu_pkg::COUNT_BITS-1:0] cnt_in);
    body_t b;
    b.emit = 1'b0;
    b.r    = '0;
    b.mode = qlu_pkg::MODE_NORMAL;
    b.cnt  = cnt_in;
    if (c == close_c || c == qlu_pkg::CHAR_NUL) begin
      b.emit = 1'b1;
      b.r    = qlu_pkg::make_res(qlu_pkg::KIND_DONE, 8'd0, qlu_pkg::count_out(cnt_in));
      b.mode = qlu_pkg::MODE_IDLE;
    end else if (c == qlu_pkg::CHAR_BSLASH) begin
      b.mode = qlu_pkg::MODE_ESCAPE;
    end else begin
      b.emit = 1'b1;
      b.r    = qlu_pkg::make_res(qlu_pkg::KIND_CHAR, c, 16'd0);
      b.cnt  = qlu_pkg::sat_inc(cnt_in);
    end
    return b;
  endfunction

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_char  <= qlu_pkg::OPEN_RESET;
      close_char <= qlu_pkg::CLOSE_RESET;
    end else if (cfg_we) begin
      case (qlu_pkg::cfg_idx_t'(cfg_index))
        qlu_pkg::CFG_OPEN:  open_char  <= cfg_data;
        qlu_pkg::CFG_CLOSE: close_char <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= qlu_pkg::MODE_IDLE;
      octal_value   <= '0;
      octal_digits  <= '0;
      emitted_count <= '0;
    end else begin
      mode          <= mode_next;
      octal_value   <= octal_value_next;
      octal_digits  <= octal_digits_next;
      emitted_count <= emitted_count_next;
    end
  end

  always_comb begin
    logic [7:0]                     c;
    qlu_pkg::mode_t                 mode_e;
    logic [7:0]                     ov_e;
    logic [1:0]                     od_e;
    logic [qlu_pkg::COUNT_BITS-1:0] cnt_e;
    logic [qlu_pkg::COUNT_BITS-1:0] cnt1;
    logic [7:0]                     nv;
    logic [1:0]                     nd;
    body_t                          b;

    c                  = in_chan.in_byte;
    mode_next          = mode;
    octal_value_next   = octal_value;
    octal_digits_next  = octal_digits;
    emitted_count_next = emitted_count;
    push               = '0;
    mode_e             = mode;
    ov_e               = octal_value;
    od_e               = octal_digits;
    cnt_e              = emitted_count;
    cnt1               = qlu_pkg::sat_inc(emitted_count);
    nv                 = '0;
    nd                 = '0;
    b                  = '0;

    if (accept) begin
      if (in_chan.start_req) begin
        mode_e             = qlu_pkg::MODE_NORMAL;
        ov_e               = '0;
        od_e               = '0;
        cnt_e              = '0;
        mode_next          = qlu_pkg::MODE_NORMAL;
        octal_value_next   = '0;
        octal_digits_next  = '0;
        emitted_count_next = '0;
      end
      if (in_chan.start_req && open_char != qlu_pkg::CHAR_NUL) begin
        if (c != open_char) begin
          push.n    = 2'd1;
          push.r0   = qlu_pkg::make_res(qlu_pkg::KIND_ERR, 8'd0, 16'd0);
          mode_next = qlu_pkg::MODE_IDLE;
        end
      end else begin
        case (mode_e)
          qlu_pkg::MODE_NORMAL: begin
            b                  = body_byte(c, close_char, cnt_e);
            push.n             = {1'b0, b.emit};
            push.r0            = b.r;
            mode_next          = b.mode;
            emitted_count_next = b.cnt;
          end
          qlu_pkg::MODE_ESCAPE: begin
            if (c == qlu_pkg::CHAR_NUL) begin
              push.n    = 2'd1;
              push.r0   = qlu_pkg::make_res(qlu_pkg::KIND_DONE, 8'd0,
                                            qlu_pkg::count_out(cnt_e));
              mode_next = qlu_pkg::MODE_IDLE;
            end else if (qlu_pkg::is_octal(c)) begin
              octal_value_next  = {5'd0, c[2:0]};
              octal_digits_next = 2'd1;
              mode_next         = qlu_pkg::MODE_OCTAL;
            end else begin
              push.n             = 2'd1;
              push.r0            = qlu_pkg::make_res(qlu_pkg::KIND_CHAR,
                                                     qlu_pkg::escape_map(c), 16'd0);
              mode_next          = qlu_pkg::MODE_NORMAL;
              emitted_count_next = qlu_pkg::sat_inc(cnt_e);
            end
          end
          qlu_pkg::MODE_OCTAL: begin
            if (qlu_pkg::is_octal(c)) begin
              nv               = {ov_e[4:0], c[2:0]};
              nd               = od_e + 2'd1;
              octal_value_next = nv;
              if (nd == 2'd3 || nd == 2'd0) begin
                push.n             = 2'd1;
                push.r0            = qlu_pkg::make_res(qlu_pkg::KIND_CHAR, nv, 16'd0);
                mode_next          = qlu_pkg::MODE_NORMAL;
                octal_digits_next  = 2'd0;
                emitted_count_next = qlu_pkg::sat_inc(cnt_e);
              end else begin
                octal_digits_next = nd;
              end
            end else begin
              // Emit the pending octal character, then treat this byte as body.
              cnt1               = qlu_pkg::sat_inc(cnt_e);
              b                  = body_byte(c, close_char, cnt1);
              push.n             = b.emit ? 2'd2 : 2'd1;
              push.r0            = qlu_pkg::make_res(qlu_pkg::KIND_CHAR, ov_e, 16'd0);
              push.r1            = b.r;
              mode_next          = b.mode;
              octal_digits_next  = 2'd0;
              emitted_count_next = b.cnt;
            end
          end
          default: mode_next = qlu_pkg::MODE_IDLE;
        endcase
      end
      if (push.n == 2'd1) push.r0.last = 1'b1;
      if (push.n == 2'd2) push.r1.last = 1'b1;
    end
  end

  // An opening error only comes from a start byte and stands alone.
  a_err_on_start: assert property (@(posedge clk) disable iff (rst)
    (accept && push.n != 2'd0 && push.r0.kind == qlu_pkg::KIND_ERR)
      |-> (in_chan.start_req && push.n == 2'd1))
    else $error("opening error outside a start byte");

  // Two words only when an octal escape is cut short.
  a_two_from_octal: assert property (@(posedge clk) disable iff (rst)
    (accept && push.n == 2'd2)
      |-> (mode == qlu_pkg::MODE_OCTAL && !in_chan.start_req))
    else $error("two words outside a cut octal escape");

  // A finished word leaves the decoder idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && ((push.n == 2'd1 && push.r0.kind == qlu_pkg::KIND_DONE) ||
                (push.n == 2'd2 && push.r1.kind == qlu_pkg::KIND_DONE)))
      |=> (mode == qlu_pkg::MODE_IDLE))
    else $error("decoder not idle after finished word");

endmodule

// ===== design/qlu_fifo.sv =====
// ----------------------------------------------------------------------------
// qlu_fifo: result word queue
// Takes up to two decoder words a cycle, hands out one a cycle to a ready sink.
// ----------------------------------------------------------------------------
module qlu_fifo (
  input  logic           clk,
  input  logic           rst,
  input  qlu_pkg::push_t push,
  output logic           room,
  qlu_out_if.source      out_chan
);

  localparam int FILL_BITS = qlu_pkg::FIFO_AW + 1;

  qlu_pkg::res_t                mem [qlu_pkg::FIFO_DEPTH];
  logic [qlu_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [qlu_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [FILL_BITS-1:0]         fill;
  logic [FILL_BITS-1:0]         fill_next;
  logic                         pop;
  qlu_pkg::res_t                head;

  // Room for a worst-case pair of words.
  assign room = (fill <= FILL_BITS'(qlu_pkg::FIFO_DEPTH - 2));
  assign pop  = out_chan.valid && out_chan.ready;
  assign head = mem[rd_ptr];

  assign out_chan.valid       = (fill != '0);
  assign out_chan.result_kind = head.kind;
  assign out_chan.char_value  = head.value;
  assign out_chan.char_count  = head.count;
  assign out_chan.last        = head.last;

  assign fill_next = fill + FILL_BITS'(push.n) - FILL_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + qlu_pkg::FIFO_AW'(push.n);
      rd_ptr <= rd_ptr + qlu_pkg::FIFO_AW'(pop);
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + qlu_pkg::FIFO_AW'(1)] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_BITS'(qlu_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_pair_fill: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2 && !pop) |=> (fill == $past(fill) + FILL_BITS'(2)))
    else $error("word pair not counted");

endmodule

// ===== design/quoted_literal_unescaper_top.sv =====
// ----------------------------------------------------------------------------
// quoted_literal_unescaper_top: streaming decoder of C-style quoted literals
// Checks the opening quote, decodes backslash escapes and reports the count.
// ----------------------------------------------------------------------------
//
//   channel    dir   words                              handshake
//   ---------  ----  ---------------------------------  ------------
//   in_chan    in    in_byte, start_req                 valid/ready
//   out_chan   out   result_kind, char_value,           valid/ready
//                    char_count, last
//   cfg        in    cfg_index, cfg_data                cfg_we only
//
// Each accepted byte is decoded in the same cycle it is taken and its words
// land in a four-entry result queue that feeds out_chan in order. One byte
// per clock is taken while the queue has room for two words; a cut octal
// escape can make two words, so the queue drain of at most one word a clock
// sets the rate in that case. Reset (rst, synchronous) restores both quote
// bytes to 34, idles the decoder and empties the queue. A stalled out_chan
// holds its word and drops in_chan ready once the queue is near full.
//
module quoted_literal_unescaper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  qlu_in_if.sink     in_chan,
  qlu_out_if.source  out_chan
);

  qlu_pkg::push_t push;
  logic           room;

  // Decode the incoming byte against the current escape state.
  qlu_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .room      (room),
    .push      (push)
  );

  // Hold result words until the sink takes them.
  qlu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule
